/* src/assert_macros.svh */
// Assertion macros shared by the frame receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SFRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define SFRC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* src/sfrc_pkg.sv */
// Types, codes and the CRC-8 function shared by the frame receiver modules.
package sfrc_pkg;

  localparam logic [7:0] SYNC1_BYTE   = 8'h5A;
  localparam logic [7:0] SYNC2_BYTE   = 8'hA5;
  localparam logic [7:0] CRC_POLY     = 8'h07;
  localparam logic [6:0] MAX_LEN_RST  = 7'd64;
  localparam logic [7:0] TEXT_CMD_RST = 8'h74;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_CMD = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_ADDR,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CRC
  } phase_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SHOW
  } back_e;

  typedef enum logic [1:0] {
    ST_TEXT    = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_CRC_ERR = 2'd2,
    ST_LEN_ERR = 2'd3
  } status_e;

  // One frame report handed from the parser to the replay engine.
  typedef struct packed {
    status_e    status;
    logic [7:0] dest_addr;
    logic [7:0] command;
    logic [7:0] length;
    logic [7:0] computed_crc;
    logic [7:0] received_crc;
    logic       payload;
  } job_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage

/* src/sfrc_front.sv */
// Frame parser: sync hunt, header capture, CRC update and payload writes.
`include "assert_macros.svh"
module sfrc_front import sfrc_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic [7:0]           rx_byte_i,
  input  logic                 resync_i,
  input  logic                 back_busy_i,
  input  logic                 q_empty_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output job_t                 job_o,
  output logic                 wr_en_o,
  output logic [((BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1)-1:0] wr_addr_o,
  output logic [7:0]           wr_data_o
);

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
  localparam logic [7:0] DEPTH_B = 8'(BUFFER_DEPTH);

  phase_e           phase_q, phase_d;
  logic [7:0]       crc_q, crc_d;
  logic [7:0]       addr_q, addr_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       len_q, len_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [6:0]       max_len_q;
  logic [7:0]       text_cmd_q;
  logic [7:0]       limit;
  logic [7:0]       crc_next;
  logic [7:0]       crc_first;
  logic             accept;
  logic             take;

  assign limit     = ({1'b0, max_len_q} > DEPTH_B) ? DEPTH_B : {1'b0, max_len_q};
  assign crc_next  = crc8_byte(crc_q, rx_byte_i);
  assign crc_first = crc8_byte(8'h00, rx_byte_i);

  // Stall on a full queue; hold payload while an earlier frame is pending.
  assign s_ready_o = !q_full_i && !(phase_q == PH_DATA && (back_busy_i || !q_empty_i));
  assign accept    = s_valid_i && s_ready_o;
  assign take      = accept && !resync_i;

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      if (resync_i) begin
        phase_d = PH_SYNC1;
      end else begin
        case (phase_q)
          PH_SYNC1: if (rx_byte_i == SYNC1_BYTE) phase_d = PH_SYNC2;
          PH_SYNC2: phase_d = (rx_byte_i == SYNC2_BYTE) ? PH_ADDR : PH_SYNC1;
          PH_ADDR:  phase_d = PH_CMD;
          PH_CMD:   phase_d = PH_LEN;
          PH_LEN: begin
            if (rx_byte_i > limit) phase_d = PH_SYNC1;
            else if (rx_byte_i != 8'h00) phase_d = PH_DATA;
            else phase_d = PH_CRC;
          end
          PH_DATA:  if (rem_q == CNT_W'(1)) phase_d = PH_CRC;
          PH_CRC:   phase_d = PH_SYNC1;
          default:  phase_d = PH_SYNC1;
        endcase
      end
    end
  end

  always_comb begin
    crc_d     = crc_q;
    addr_d    = addr_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    idx_d     = idx_q;
    rem_d     = rem_q;
    push_o    = 1'b0;
    wr_en_o   = 1'b0;
    wr_addr_o = idx_q[IDX_W-1:0];
    wr_data_o = rx_byte_i;
    job_o.status       = ST_LEN_ERR;
    job_o.dest_addr    = addr_q;
    job_o.command      = cmd_q;
    job_o.length       = len_q;
    job_o.computed_crc = crc_q;
    job_o.received_crc = 8'h00;
    job_o.payload      = 1'b0;
    if (take) begin
      case (phase_q)
        PH_SYNC1: begin
          if (rx_byte_i == SYNC1_BYTE) begin
            crc_d = 8'h00;
            idx_d = '0;
          end
        end
        PH_ADDR: begin
          addr_d = rx_byte_i;
          crc_d  = crc_first;
          idx_d  = '0;
        end
        PH_CMD: begin
          cmd_d = rx_byte_i;
          crc_d = crc_next;
        end
        PH_LEN: begin
          crc_d = crc_next;
          len_d = rx_byte_i;
          if (rx_byte_i > limit) begin
            push_o             = 1'b1;
            job_o.length       = rx_byte_i;
            job_o.computed_crc = crc_next;
          end else begin
            rem_d = rx_byte_i[CNT_W-1:0];
            idx_d = '0;
          end
        end
        PH_DATA: begin
          wr_en_o = 1'b1;
          idx_d   = idx_q + CNT_W'(1);
          rem_d   = rem_q - CNT_W'(1);
          crc_d   = crc_next;
        end
        PH_CRC: begin
          push_o             = 1'b1;
          job_o.received_crc = rx_byte_i;
          if (crc_q != rx_byte_i) begin
            job_o.status = ST_CRC_ERR;
          end else begin
            job_o.status  = (cmd_q == text_cmd_q) ? ST_TEXT : ST_UNKNOWN;
            job_o.payload = (len_q != 8'h00);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SYNC1;
      crc_q      <= 8'h00;
      addr_q     <= 8'h00;
      cmd_q      <= 8'h00;
      len_q      <= 8'h00;
      idx_q      <= '0;
      rem_q      <= '0;
      max_len_q  <= MAX_LEN_RST;
      text_cmd_q <= TEXT_CMD_RST;
    end else begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      addr_q  <= addr_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      rem_q   <= rem_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MAX_LEN:  max_len_q  <= cfg_wdata_i[6:0];
          CFG_TEXT_CMD: text_cmd_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  `SFRC_ASSERT_NEVER(a_wr_during_replay, wr_en_o && (back_busy_i || !q_empty_i), "payload write while buffer in use")

endmodule

/* src/sfrc_queue.sv */
// Two-entry queue of frame reports between parser and replay engine.
`include "assert_macros.svh"
module sfrc_queue import sfrc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o,
  output logic full_o
);

  job_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign job_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + QCNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

  `SFRC_ASSERT_NEVER(a_push_full, push_i && full_o, "push into full queue")
  `SFRC_ASSERT_NEVER(a_pop_empty, pop_i && empty_o, "pop from empty queue")

endmodule

/* src/sfrc_back.sv */
// Replay engine: payload buffer and result generation from frame reports.
`include "assert_macros.svh"
module sfrc_back import sfrc_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  job_t                   q_job_i,
  input  logic                   q_empty_i,
  output logic                   pop_o,
  input  logic                   wr_en_i,
  input  logic [((BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [7:0]             wr_data_i,
  output logic                   busy_o,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0] m_tdata_o,
  output logic [OUT_TUSER_W-1:0] m_tuser_o,
  output logic                   m_tlast_o
);

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

  logic [7:0]       mem [BUFFER_DEPTH];
  logic [7:0]       rdata_q;
  back_e            state_q, state_d;
  job_t             job_q;
  logic [CNT_W-1:0] idx_q;
  logic             rd_en;
  logic             last_item;
  logic [7:0]       data_byte;

  assign last_item = !job_q.payload || ((idx_q + CNT_W'(1)) == job_q.length[CNT_W-1:0]);
  assign data_byte = job_q.payload ? rdata_q : 8'h00;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (!q_empty_i) state_d = q_job_i.payload ? B_READ : B_SHOW;
      B_READ: state_d = B_SHOW;
      B_SHOW: if (m_tready_i) state_d = last_item ? B_IDLE : B_READ;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o      = (state_q == B_IDLE) && !q_empty_i;
    rd_en      = (state_q == B_READ);
    busy_o     = (state_q != B_IDLE);
    m_tvalid_o = (state_q == B_SHOW);
    m_tlast_o  = last_item;
    m_tdata_o  = {job_q.received_crc, job_q.computed_crc, data_byte,
                  job_q.length, job_q.command, job_q.dest_addr};
    m_tuser_o  = {job_q.payload, job_q.status};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en)   rdata_q <= mem[idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= q_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (pop_o) idx_q <= '0;
      else if (state_q == B_SHOW && m_tready_i && !last_item) idx_q <= idx_q + CNT_W'(1);
    end
  end

  `SFRC_ASSERT(a_idx_in_range, (state_q == B_SHOW && job_q.payload) |-> (idx_q < job_q.length[CNT_W-1:0]), "replay index past frame length")

endmodule

/* src/sync_framed_rx_crc8_checker.sv */
// Top level of the sync-framed receiver with CRC-8 check.
//
// Input stream: one received byte per request in s_axis_tdata_i; s_axis_tuser_i
// set forces the parser back to the sync hunt and the byte is ignored.
// The parser hunts for 0x5A 0xA5, captures address, command and length, stores
// the payload and checks CRC-8 (poly 0x07, init 0) over header and payload.
// Output stream: one result per payload byte of a good frame, or one result
// for a zero-length frame, a CRC error or a length error; tlast marks the end
// and tuser carries the status and the data-valid flag.
// Header and CRC bytes are taken one per cycle while the report queue is not
// full. Replay reads each payload byte through the registered read of the
// payload buffer followed by the output stage. A two-entry report queue lets
// the parser take the next frame's header while results drain; payload bytes
// of the next frame wait until the buffer is no longer being replayed.
// Reset returns the parser to the sync hunt, empties the queue and restores
// max_payload_len = 64 and text_command = 't'. When the receiver stalls the
// current result holds and the input stalls once the queue or buffer is busy.
module sync_framed_rx_crc8_checker import sfrc_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [7:0]             cfg_wdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,  // [7:0] rx_byte
  input  logic [0:0]             s_axis_tuser_i,  // [0] resync
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [7:0] dest_addr, [15:8] command, [23:16] length, [31:24] data_byte,
  // [39:32] computed_crc, [47:40] received_crc
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,  // [1:0] status, [2] data_valid
  output logic                   m_axis_tlast_o
);

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  job_t             push_job, q_job;
  logic             push, pop, q_empty, q_full, back_busy;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;

  sfrc_front #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .rx_byte_i   (s_axis_tdata_i),
    .resync_i    (s_axis_tuser_i[0]),
    .back_busy_i (back_busy),
    .q_empty_i   (q_empty),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  sfrc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (q_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  sfrc_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_job_i    (q_job),
    .q_empty_i  (q_empty),
    .pop_o      (pop),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .busy_o     (back_busy),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

/* tb/tb_sync_framed_rx_crc8_checker.sv */
// Self-checking testbench for the sync-framed CRC-8 receiver: frame predictor and stream drivers.
module tb_sync_framed_rx_crc8_checker;
  timeunit 1ns;
  timeprecision 1ps;

  import sfrc_pkg::*;

  localparam int BUF_DEPTH   = 64;
  localparam int PHASE_ITEMS = 70;
  localparam int DRAIN_WAIT  = 16;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    status_e    status;
    logic [7:0] dest_addr;
    logic [7:0] command;
    logic [7:0] length;
    logic [7:0] data_byte;
    logic       data_valid;
    logic [7:0] computed_crc;
    logic [7:0] received_crc;
    logic       last;
  } frame_result_t;

  class frame_scoreboard;
    phase_e        rx_phase;
    logic [7:0]    frame_crc;
    logic [7:0]    payload_buf [BUF_DEPTH];
    logic [6:0]    wr_ptr;
    logic [6:0]    bytes_left;
    logic [7:0]    hdr_addr;
    logic [7:0]    hdr_cmd;
    logic [6:0]    hdr_len;
    logic [6:0]    len_limit_reg;
    logic [7:0]    text_cmd_reg;
    frame_result_t expected_q[$];
    int unsigned   errors;

    function new();
      rx_phase      = PH_SYNC1;
      frame_crc     = 8'h00;
      wr_ptr        = '0;
      bytes_left    = '0;
      hdr_addr      = 8'h00;
      hdr_cmd       = 8'h00;
      hdr_len       = '0;
      len_limit_reg = MAX_LEN_RST;
      text_cmd_reg  = TEXT_CMD_RST;
      errors        = 0;
    endfunction

    // Bitwise CRC-8, MSB first, poly 0x07.
    static function logic [7:0] crc_update(logic [7:0] c, logic [7:0] b);
      logic [7:0] r;
      logic       fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
        fb = r[7] ^ b[i];
        r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return r;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
      if (idx == CFG_MAX_LEN) begin
        len_limit_reg = value[6:0];
      end else if (idx == CFG_TEXT_CMD) begin
        text_cmd_reg = value;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push(status_e st, logic [7:0] len, logic [7:0] data, logic valid,
                       logic [7:0] rcrc, logic last);
      frame_result_t r;
      r.status       = st;
      r.dest_addr    = hdr_addr;
      r.command      = hdr_cmd;
      r.length       = len;
      r.data_byte    = data;
      r.data_valid   = valid;
      r.computed_crc = frame_crc;
      r.received_crc = rcrc;
      r.last         = last;
      expected_q.push_back(r);
    endfunction

    // Advance the frame parser by one accepted request.
    function void note_request(logic [7:0] b, logic resync);
      int      lim;
      int      n;
      status_e cls;
      if (resync) begin
        rx_phase = PH_SYNC1;
        return;
      end
      case (rx_phase)
        PH_SYNC1: begin
          if (b == SYNC1_BYTE) begin
            rx_phase  = PH_SYNC2;
            wr_ptr    = '0;
            frame_crc = 8'h00;
          end
        end
        PH_SYNC2: begin
          rx_phase = (b == SYNC2_BYTE) ? PH_ADDR : PH_SYNC1;
        end
        PH_ADDR: begin
          hdr_addr  = b;
          frame_crc = crc_update(8'h00, b);
          wr_ptr    = '0;
          rx_phase  = PH_CMD;
        end
        PH_CMD: begin
          hdr_cmd   = b;
          frame_crc = crc_update(frame_crc, b);
          rx_phase  = PH_LEN;
        end
        PH_LEN: begin
          frame_crc = crc_update(frame_crc, b);
          lim = (len_limit_reg > BUF_DEPTH) ? BUF_DEPTH : len_limit_reg;
          hdr_len = b[6:0];
          if (b > lim) begin
            push(ST_LEN_ERR, b, 8'h00, 1'b0, 8'h00, 1'b1);
            rx_phase = PH_SYNC1;
          end else begin
            bytes_left = b[6:0];
            wr_ptr     = '0;
            rx_phase   = (b != 0) ? PH_DATA : PH_CRC;
          end
        end
        PH_DATA: begin
          if (wr_ptr < BUF_DEPTH) payload_buf[wr_ptr] = b;
          wr_ptr     = wr_ptr + 7'd1;
          frame_crc  = crc_update(frame_crc, b);
          bytes_left = bytes_left - 7'd1;
          if (bytes_left == 0) rx_phase = PH_CRC;
        end
        PH_CRC: begin
          if (frame_crc != b) begin
            push(ST_CRC_ERR, {1'b0, hdr_len}, 8'h00, 1'b0, b, 1'b1);
          end else begin
            cls = (hdr_cmd == text_cmd_reg) ? ST_TEXT : ST_UNKNOWN;
            n = (hdr_len > BUF_DEPTH) ? BUF_DEPTH : hdr_len;
            if (n == 0) begin
              push(cls, {1'b0, hdr_len}, 8'h00, 1'b0, b, 1'b1);
            end else begin
              for (int i = 0; i < n; i++) begin
                push(cls, {1'b0, hdr_len}, payload_buf[i], 1'b1, b, (i == n - 1));
              end
            end
          end
          rx_phase = PH_SYNC1;
        end
        default: rx_phase = PH_SYNC1;
      endcase
    endfunction

    task report(string msg);
      if (errors < 200) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] td, logic [OUT_TUSER_W-1:0] tu, logic tl);
      frame_result_t w;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h/%h with nothing expected", td, tu));
        return;
      end
      w = expected_q.pop_front();
      if (tu[1:0] != w.status)
        report($sformatf("status got %0d want %0d", tu[1:0], w.status));
      if (td[7:0] != w.dest_addr)
        report($sformatf("dest_addr got %h want %h", td[7:0], w.dest_addr));
      if (td[15:8] != w.command)
        report($sformatf("command got %h want %h", td[15:8], w.command));
      if (td[23:16] != w.length)
        report($sformatf("length got %h want %h", td[23:16], w.length));
      if (td[31:24] != w.data_byte)
        report($sformatf("data_byte got %h want %h", td[31:24], w.data_byte));
      if (tu[2] != w.data_valid)
        report($sformatf("data_valid got %b want %b", tu[2], w.data_valid));
      if (td[39:32] != w.computed_crc)
        report($sformatf("computed_crc got %h want %h", td[39:32], w.computed_crc));
      if (td[47:40] != w.received_crc)
        report($sformatf("received_crc got %h want %h", td[47:40], w.received_crc));
      if (tl != w.last)
        report($sformatf("last got %b want %b", tl, w.last));
    endtask
  endclass

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic                   cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx  = CFG_MAX_LEN;
  logic [7:0]             cfg_data = 8'h00;
  logic                   s_valid  = 1'b0;
  logic                   s_ready;
  logic [7:0]             s_data   = 8'h00;
  logic [0:0]             s_user   = 1'b0;
  logic                   m_valid;
  logic                   m_ready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;
  logic [OUT_TUSER_W-1:0] m_user;
  logic                   m_last;

  frame_scoreboard sb;
  int          src_idle_pct = 0;
  int          dst_stall_pct = 0;
  int          items_sent = 0;
  logic [6:0]  cur_max = MAX_LEN_RST;
  bit          hold_kick = 1'b0;
  int          hold_left = 0;

  sync_framed_rx_crc8_checker #(
    .BUFFER_DEPTH(BUF_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_idx),
    .cfg_wdata_i    (cfg_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: check accepted results, then pick next ready.
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) sb.check_result(m_data, m_user, m_last);
    if (hold_kick) begin
      hold_left = HOLD_CYCLES;
      hold_kick = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= dst_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic resync);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_user  <= resync;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sb.note_request(b, resync);
    items_sent++;
  endtask

  function automatic int cur_limit();
    return (cur_max > BUF_DEPTH) ? BUF_DEPTH : cur_max;
  endfunction

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
                            input logic [7:0] len, input bit corrupt);
    logic [7:0] c;
    logic [7:0] d;
    send_byte(SYNC1_BYTE, 1'b0);
    send_byte(SYNC2_BYTE, 1'b0);
    c = frame_scoreboard::crc_update(8'h00, addr);
    send_byte(addr, 1'b0);
    c = frame_scoreboard::crc_update(c, cmd);
    send_byte(cmd, 1'b0);
    c = frame_scoreboard::crc_update(c, len);
    send_byte(len, 1'b0);
    if (len > cur_limit()) return;
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom_range(0, 255));
      c = frame_scoreboard::crc_update(c, d);
      send_byte(d, 1'b0);
    end
    if (corrupt) c = c ^ 8'($urandom_range(1, 255));
    send_byte(c, 1'b0);
  endtask

  // Mostly well-formed frames; some noise, resyncs and broken sync pairs.
  task automatic send_random();
    int         r;
    int         s;
    int         lim;
    logic [7:0] b;
    logic [7:0] cmd;
    logic [7:0] len;
    lim = cur_limit();
    r = $urandom_range(0, 99);
    if (r < 6) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (r < 10) begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end else if (r < 14) begin
      b = 8'($urandom_range(0, 255));
      if (b == SYNC2_BYTE) b = SYNC1_BYTE;
      send_byte(SYNC1_BYTE, 1'b0);
      send_byte(b, 1'b0);
    end else begin
      if ($urandom_range(0, 2) == 0) send_byte(8'($urandom_range(0, 255)), 1'b1);
      cmd = ($urandom_range(0, 1) == 0) ? sb.text_cmd_reg : 8'($urandom_range(0, 255));
      s = $urandom_range(0, 99);
      if (s < 75)      len = 8'($urandom_range(0, (lim < 8) ? lim : 8));
      else if (s < 85) len = 8'($urandom_range(0, lim));
      else if (s < 89) len = 8'(lim);
      else             len = 8'($urandom_range(lim + 1, 255));
      send_frame(8'($urandom_range(0, 255)), cmd, len, $urandom_range(0, 4) == 0);
    end
  endtask

  task automatic set_regs(input logic [7:0] max_len, input logic [7:0] text_cmd);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_MAX_LEN;
    cfg_data <= max_len;
    @(posedge clk_i);
    cfg_idx  <= CFG_TEXT_CMD;
    cfg_data <= text_cmd;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.write_reg(CFG_MAX_LEN, max_len);
    sb.write_reg(CFG_TEXT_CMD, text_cmd);
    cur_max = max_len[6:0];
  endtask

  // Drop valid and let every expected result arrive.
  task automatic drain();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at reset register values.
    send_byte(SYNC1_BYTE, 1'b0);
    send_byte(SYNC1_BYTE, 1'b0);
    send_byte(SYNC2_BYTE, 1'b0);
    send_frame(8'hFF, 8'hFF, 8'd1, 1'b0);
    send_frame(8'h00, TEXT_CMD_RST, 8'd0, 1'b0);
    send_byte(SYNC1_BYTE, 1'b0);
    send_byte(SYNC2_BYTE, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_frame(8'h00, 8'h00, 8'hFF, 1'b0);
    send_frame(8'h12, 8'h34, 8'd0, 1'b1);
    drain();

    for (int p = 1; p <= 5; p++) begin
      case (p)
        1: set_regs(8'd64, TEXT_CMD_RST);
        2: set_regs(8'd0, 8'h00);
        3: set_regs(8'hFF, 8'hFF);
        4: set_regs(8'($urandom_range(1, 63)), 8'($urandom_range(0, 255)));
        default: set_regs(8'd64, 8'($urandom_range(0, 255)));
      endcase
      case (p)
        2: begin src_idle_pct = 79; dst_stall_pct = 0;  end
        3: begin src_idle_pct = 0;  dst_stall_pct = 79; end
        4: begin src_idle_pct = 21; dst_stall_pct = 21; end
        default: begin src_idle_pct = 0; dst_stall_pct = 0; end
      endcase
      items_sent = 0;
      if (p == 1) begin
        // Hold the result side while long frames keep coming.
        hold_kick = 1'b1;
        send_frame(8'($urandom_range(0, 255)), TEXT_CMD_RST, 8'd16, 1'b0);
        send_frame(8'($urandom_range(0, 255)), 8'h00, 8'd16, 1'b0);
        send_frame(8'($urandom_range(0, 255)), TEXT_CMD_RST, 8'd20, 1'b0);
      end
      while (items_sent < PHASE_ITEMS) send_random();
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
